### rtl/gpig_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpig_pkg - grid patch index generator shared definitions
// Register indexes, field widths and point counts of the quad index runs.
// ----------------------------------------------------------------------------
package gpig_pkg;

    // Field widths fixed by the interface
    localparam int REG_W   = 8;
    localparam int INDEX_W = 16;
    localparam int SLOT_W  = 4;
    localparam int CFG_IDX_W = 2;

    // Number of indices in one quad run
    localparam logic [SLOT_W-1:0] TRI_POINTS   = 4'd6;
    localparam logic [SLOT_W-1:0] PATCH_POINTS = 4'd12;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUAD_ROWS    = 2'd0,
        CFG_QUAD_COLUMNS = 2'd1,
        CFG_PATCH_MODE   = 2'd2
    } cfg_index_t;

    // Output ordering modes
    localparam logic MODE_TRIANGLES = 1'b0;
    localparam logic MODE_PATCH     = 1'b1;

    // Reset values of the configuration registers
    localparam logic [REG_W-1:0] QUAD_ROWS_RESET    = 8'd1;
    localparam logic [REG_W-1:0] QUAD_COLUMNS_RESET = 8'd1;

endpackage

### rtl/gpig_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpig_walk - quad position walker
// Holds the current quad position, resolves restart and out-of-grid cases,
// and prepares the clamped neighbour coordinates of the quad being issued.
// ----------------------------------------------------------------------------
module gpig_walk
    import gpig_pkg::*;
#(
    parameter int MAX_SIDE = 255,
    localparam int SIDE_W  = $clog2(MAX_SIDE + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              restart,
    input  logic [REG_W-1:0]  quad_rows,
    input  logic [REG_W-1:0]  quad_columns,
    output logic [SIDE_W-1:0] row,
    output logic [SIDE_W-1:0] row_p1,
    output logic [SIDE_W-1:0] row_p2,
    output logic [SIDE_W-1:0] row_m1,
    output logic [SIDE_W-1:0] col,
    output logic [SIDE_W-1:0] col_p1,
    output logic [SIDE_W-1:0] col_p2,
    output logic [SIDE_W-1:0] col_m1,
    output logic [SIDE_W:0]   per_row,
    output logic              grid_end
);

    localparam int WIDE_W = (SIDE_W > REG_W) ? SIDE_W : REG_W;

    // Effective grid side: zero acts as one, large values saturate
    function automatic logic [SIDE_W-1:0] eff_size(input logic [REG_W-1:0] v);
        logic [WIDE_W-1:0] wide;
        wide = WIDE_W'(v);
        if (v == '0)
            eff_size = SIDE_W'(1);
        else if (wide > WIDE_W'(MAX_SIDE))
            eff_size = SIDE_W'(MAX_SIDE);
        else
            eff_size = SIDE_W'(wide);
    endfunction

    logic [SIDE_W-1:0] cur_row_reg, cur_row_next;
    logic [SIDE_W-1:0] cur_col_reg, cur_col_next;
    logic [SIDE_W-1:0] rows_eff, cols_eff;
    logic [SIDE_W:0]   row_p2_wide, col_p2_wide;
    logic              rewind;

    // Resolve the position of the quad to issue
    always_comb
    begin
        rows_eff = eff_size(quad_rows);
        cols_eff = eff_size(quad_columns);
        rewind   = restart || (cur_row_reg >= rows_eff) || (cur_col_reg >= cols_eff);
        row      = rewind ? '0 : cur_row_reg;
        col      = rewind ? '0 : cur_col_reg;
        row_p1   = row + SIDE_W'(1);
        col_p1   = col + SIDE_W'(1);
        row_m1   = (row == '0) ? '0 : row - SIDE_W'(1);
        col_m1   = (col == '0) ? '0 : col - SIDE_W'(1);
        row_p2_wide = {1'b0, row} + (SIDE_W + 1)'(2);
        col_p2_wide = {1'b0, col} + (SIDE_W + 1)'(2);
        row_p2   = (row_p2_wide > {1'b0, rows_eff}) ? rows_eff : row_p2_wide[SIDE_W-1:0];
        col_p2   = (col_p2_wide > {1'b0, cols_eff}) ? cols_eff : col_p2_wide[SIDE_W-1:0];
        per_row  = {1'b0, cols_eff} + (SIDE_W + 1)'(1);
        grid_end = (row_p1 == rows_eff) && (col_p1 == cols_eff);
    end

    // Advance in row-major order, wrap after the last quad
    always_comb
    begin
        if (col_p1 >= cols_eff)
        begin
            cur_col_next = '0;
            cur_row_next = (row_p1 >= rows_eff) ? '0 : row_p1;
        end
        else
        begin
            cur_col_next = col_p1;
            cur_row_next = row;
        end
    end

    // Hold the walk position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
        end
        else if (load)
        begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
        end
    end

endmodule

### rtl/gpig_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpig_emit - quad index emitter
// Holds one quad, steps a slot counter over its index run and forms one
// vertex index per cycle into the output register unless it is stalled.
// ----------------------------------------------------------------------------
module gpig_emit
    import gpig_pkg::*;
#(
    parameter int MAX_SIDE = 255,
    localparam int SIDE_W  = $clog2(MAX_SIDE + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               mode,
    input  logic [SIDE_W-1:0]  row,
    input  logic [SIDE_W-1:0]  row_p1,
    input  logic [SIDE_W-1:0]  row_p2,
    input  logic [SIDE_W-1:0]  row_m1,
    input  logic [SIDE_W-1:0]  col,
    input  logic [SIDE_W-1:0]  col_p1,
    input  logic [SIDE_W-1:0]  col_p2,
    input  logic [SIDE_W-1:0]  col_m1,
    input  logic [SIDE_W:0]    per_row,
    input  logic               grid_end,
    output logic               take,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [INDEX_W-1:0] vertex_index,
    output logic [SLOT_W-1:0]  slot,
    output logic               last_of_quad,
    output logic               last_of_grid
);

    localparam int PROD_W = 2 * SIDE_W + 1;

    // Held quad
    logic              busy_reg;
    logic              mode_reg;
    logic [SIDE_W-1:0] row_reg, row_p1_reg, row_p2_reg, row_m1_reg;
    logic [SIDE_W-1:0] col_reg, col_p1_reg, col_p2_reg, col_m1_reg;
    logic [SIDE_W:0]   per_row_reg;
    logic              grid_end_reg;
    logic [SLOT_W-1:0] slot_reg;

    // Output word
    logic               out_valid_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [SLOT_W-1:0]  slot_out_reg;
    logic               last_quad_reg;
    logic               last_grid_reg;

    logic              step;
    logic              final_slot;
    logic [SIDE_W-1:0] sel_row, sel_col;
    logic [PROD_W-1:0] vertex_full;

    // Advance when the output register is free or being drained
    assign step       = busy_reg && (!out_valid_reg || out_ready);
    assign final_slot = (slot_reg == ((mode_reg == MODE_PATCH) ? PATCH_POINTS - 4'd1
                                                               : TRI_POINTS - 4'd1));
    assign take       = !busy_reg || (step && final_slot);

    // Pick the vertex coordinate for the current slot
    always_comb
    begin
        sel_row = row_reg;
        sel_col = col_reg;
        if (mode_reg == MODE_TRIANGLES)
        begin
            case (slot_reg)
                4'd0:    begin sel_row = row_reg;    sel_col = col_reg;    end
                4'd1:    begin sel_row = row_reg;    sel_col = col_p1_reg; end
                4'd2:    begin sel_row = row_p1_reg; sel_col = col_reg;    end
                4'd3:    begin sel_row = row_p1_reg; sel_col = col_reg;    end
                4'd4:    begin sel_row = row_reg;    sel_col = col_p1_reg; end
                default: begin sel_row = row_p1_reg; sel_col = col_p1_reg; end
            endcase
        end
        else
        begin
            case (slot_reg)
                4'd0:    begin sel_row = row_reg;    sel_col = col_reg;    end
                4'd1:    begin sel_row = row_reg;    sel_col = col_p1_reg; end
                4'd2:    begin sel_row = row_p1_reg; sel_col = col_reg;    end
                4'd3:    begin sel_row = row_p1_reg; sel_col = col_p1_reg; end
                4'd4:    begin sel_row = row_p2_reg; sel_col = col_reg;    end
                4'd5:    begin sel_row = row_p2_reg; sel_col = col_p1_reg; end
                4'd6:    begin sel_row = row_reg;    sel_col = col_p2_reg; end
                4'd7:    begin sel_row = row_p1_reg; sel_col = col_p2_reg; end
                4'd8:    begin sel_row = row_m1_reg; sel_col = col_reg;    end
                4'd9:    begin sel_row = row_m1_reg; sel_col = col_p1_reg; end
                4'd10:   begin sel_row = row_reg;    sel_col = col_m1_reg; end
                default: begin sel_row = row_p1_reg; sel_col = col_m1_reg; end
            endcase
        end
    end

    // Linear vertex index: row times vertices per row plus column
    assign vertex_full = PROD_W'(sel_row) * PROD_W'(per_row_reg) + PROD_W'(sel_col);

    // Hold the quad and sequence its slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            slot_reg <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            slot_reg <= '0;
        end
        else if (step)
        begin
            busy_reg <= !final_slot;
            slot_reg <= slot_reg + 4'd1;
        end
    end

    // Capture the quad description
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mode_reg     <= mode;
            row_reg      <= row;
            row_p1_reg   <= row_p1;
            row_p2_reg   <= row_p2;
            row_m1_reg   <= row_m1;
            col_reg      <= col;
            col_p1_reg   <= col_p1;
            col_p2_reg   <= col_p2;
            col_m1_reg   <= col_m1;
            per_row_reg  <= per_row;
            grid_end_reg <= grid_end;
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            index_reg     <= INDEX_W'(vertex_full);
            slot_out_reg  <= slot_reg;
            last_quad_reg <= final_slot;
            last_grid_reg <= final_slot && grid_end_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = index_reg;
    assign slot         = slot_out_reg;
    assign last_of_quad = last_quad_reg;
    assign last_of_grid = last_grid_reg;

endmodule

### rtl/grid_patch_index_generator.sv
`timescale 1ns / 1ps
// The first index of a quad is registered into the output register from the quad held in the emitter.
// Each word yields 6 indices in triangle mode, 12 in patch mode;
// the emitter forms one index a cycle while the output register is free or being drained.
// The next word is taken in the cycle the last index of the current quad is issued.
// Reset (asynchronous, active low): walk at quad 0, output empty, quad_rows = 1,
// quad_columns = 1, patch_mode = 0. No clearing pass.
// ----------------------------------------------------------------------------
// grid_patch_index_generator - grid quad index generator
// Walks the quads of a vertex grid in row-major order, one quad per input
// word, and emits the quad's triangle or twelve-point patch vertex indices.
// ----------------------------------------------------------------------------
module grid_patch_index_generator
    import gpig_pkg::*;
#(
    parameter int MAX_SIDE = 255
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [REG_W-1:0]     wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 restart,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [INDEX_W-1:0]   vertex_index,
    output logic [SLOT_W-1:0]    slot,
    output logic                 last_of_quad,
    output logic                 last_of_grid
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);

    logic [REG_W-1:0]  quad_rows_reg;
    logic [REG_W-1:0]  quad_columns_reg;
    logic              patch_mode_reg;
    logic              load;
    logic              take;
    logic [SIDE_W-1:0] row, row_p1, row_p2, row_m1;
    logic [SIDE_W-1:0] col, col_p1, col_p2, col_m1;
    logic [SIDE_W:0]   per_row;
    logic              grid_end;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_rows_reg    <= QUAD_ROWS_RESET;
            quad_columns_reg <= QUAD_COLUMNS_RESET;
            patch_mode_reg   <= MODE_TRIANGLES;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_QUAD_ROWS:    quad_rows_reg    <= wr_data;
                CFG_QUAD_COLUMNS: quad_columns_reg <= wr_data;
                CFG_PATCH_MODE:   patch_mode_reg   <= wr_data[0];
                default:          ;
            endcase
        end
    end

    // Take a word when the emitter is free or finishing its quad
    assign in_ready = take;
    assign load     = in_valid && take;

    gpig_walk #(
        .MAX_SIDE (MAX_SIDE)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .restart      (restart),
        .quad_rows    (quad_rows_reg),
        .quad_columns (quad_columns_reg),
        .row          (row),
        .row_p1       (row_p1),
        .row_p2       (row_p2),
        .row_m1       (row_m1),
        .col          (col),
        .col_p1       (col_p1),
        .col_p2       (col_p2),
        .col_m1       (col_m1),
        .per_row      (per_row),
        .grid_end     (grid_end)
    );

    gpig_emit #(
        .MAX_SIDE (MAX_SIDE)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .mode         (patch_mode_reg),
        .row          (row),
        .row_p1       (row_p1),
        .row_p2       (row_p2),
        .row_m1       (row_m1),
        .col          (col),
        .col_p1       (col_p1),
        .col_p2       (col_p2),
        .col_m1       (col_m1),
        .per_row      (per_row),
        .grid_end     (grid_end),
        .take         (take),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vertex_index (vertex_index),
        .slot         (slot),
        .last_of_quad (last_of_quad),
        .last_of_grid (last_of_grid)
    );

`ifndef NO_ASSERTIONS
    // End of grid only ever marks the end of a quad
    a_grid_end_is_quad_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_grid |-> last_of_quad)
        else $error("last_of_grid without last_of_quad");

    // A quad ends only at the final slot of either run length
    a_quad_end_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_quad |->
            (slot == TRI_POINTS - 4'd1) || (slot == PATCH_POINTS - 4'd1))
        else $error("quad run ended at an unexpected slot");

    // Within a quad the slots follow one another without gaps
    a_slot_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_quad |=>
            out_valid && (slot == $past(slot) + 4'd1))
        else $error("slot sequence broken inside a quad");

    // No new word while the current quad still has indices to issue and is stalled
    a_no_take_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && !last_of_quad |-> !in_ready)
        else $error("input taken while a quad run is stalled");
`endif

endmodule
